@@ src/prd_pkg.sv @@
// pinhole ray direction: shared types and constants
// no dependencies; used by the interfaces, the square-root pipeline and the top level
`default_nettype none

package prd_pkg;

	// fixed field widths
	localparam int COMP_W  = 16;  // one Q2.14 basis component
	localparam int VEC_W   = 48;  // three packed components
	localparam int FOCAL_W = 16;  // Q14.2 focal length
	localparam int RES_W   = 13;  // resolution register
	localparam int PIX_W   = 12;  // pixel index
	localparam int JIT_W   = 4;   // jitter in eighths
	localparam int DIR_W   = 16;  // Q1.15 result component
	localparam int CFG_IDX_W = 3;

	// datapath widths
	localparam int OFS_W  = 18;   // pixel offset in eighths, signed
	localparam int PROD_W = 34;   // component times offset, signed
	localparam int SUM_W  = 36;   // unnormalised component, signed
	localparam int MAG_W  = 35;   // its magnitude
	localparam int POS_W  = 6;    // leading-one position
	localparam int NRM_W  = 30;   // normalised magnitude, top one in bit 29
	localparam int SQ_W   = 62;   // sum of three squares
	localparam int ROOT_W = 31;   // integer square root
	localparam int QUO_W  = 16;   // quotient bits
	localparam int NUM_W  = 46;   // dividend m*32768 + r/2
	localparam int REM_W  = 32;   // divider remainder

	localparam logic [DIR_W-1:0] DIR_MAX = 16'h7fff;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORWARD = 3'd0,
		REG_RIGHT   = 3'd1,
		REG_UP      = 3'd2,
		REG_FOCAL   = 3'd3,
		REG_WIDTH   = 3'd4,
		REG_HEIGHT  = 3'd5
	} cfg_reg_t;

	// reset values
	localparam logic [VEC_W-1:0]   RST_FORWARD = 48'h4000_0000_0000;
	localparam logic [VEC_W-1:0]   RST_RIGHT   = 48'h0000_0000_4000;
	localparam logic [VEC_W-1:0]   RST_UP      = 48'h0000_4000_0000;
	localparam logic [FOCAL_W-1:0] RST_FOCAL   = 16'd8868;
	localparam logic [RES_W-1:0]   RST_WIDTH   = 13'd640;
	localparam logic [RES_W-1:0]   RST_HEIGHT  = 13'd480;

	typedef logic [NRM_W-1:0] nrm_t;

	// side data that rides along the square-root pipeline
	typedef struct packed {
		nrm_t [2:0] mag;
		logic [2:0] neg;
		logic       deg;
	} carry_t;

	// pipeline control handed to a sub-unit
	typedef struct packed {
		logic en;
		logic valid;
	} pipe_ctl_t;

endpackage

`default_nettype wire

@@ src/prd_if.sv @@
// pinhole ray direction: channel interfaces for pixel items, direction items and register writes
// depends on prd_pkg
`default_nettype none

interface prd_pix_if;
	logic valid;
	logic ready;
	logic [prd_pkg::PIX_W-1:0] pixel_x;
	logic [prd_pkg::PIX_W-1:0] pixel_y;
	logic signed [prd_pkg::JIT_W-1:0] jitter_x;
	logic signed [prd_pkg::JIT_W-1:0] jitter_y;
	modport source (output valid, pixel_x, pixel_y, jitter_x, jitter_y, input ready);
	modport sink (input valid, pixel_x, pixel_y, jitter_x, jitter_y, output ready);
endinterface

interface prd_dir_if;
	logic valid;
	logic ready;
	logic signed [prd_pkg::DIR_W-1:0] dir_x;
	logic signed [prd_pkg::DIR_W-1:0] dir_y;
	logic signed [prd_pkg::DIR_W-1:0] dir_z;
	logic degenerate;
	modport source (output valid, dir_x, dir_y, dir_z, degenerate, input ready);
	modport sink (input valid, dir_x, dir_y, dir_z, degenerate, output ready);
endinterface

interface prd_cfg_if;
	logic valid;
	logic ready;
	logic [prd_pkg::CFG_IDX_W-1:0] index;
	logic [prd_pkg::VEC_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/prd_isqrt.sv @@
// pinhole ray direction: pipelined integer square root, one result bit per stage
// depends on prd_pkg
`default_nettype none

module prd_isqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire prd_pkg::pipe_ctl_t          ctl,
	input  wire logic [prd_pkg::SQ_W-1:0]    sq_sum,
	input  wire prd_pkg::carry_t             car_in,
	output logic                             out_valid,
	output logic [prd_pkg::ROOT_W-1:0]       root,
	output prd_pkg::carry_t                  car_out
);

	localparam int NSTG = prd_pkg::ROOT_W;

	logic [prd_pkg::SQ_W-1:0] rem_s[NSTG];
	logic [prd_pkg::SQ_W-1:0] res_s[NSTG];
	logic                     vld_s[NSTG];
	prd_pkg::carry_t          car_s[NSTG];

	genvar k;
	generate
		for (k = 0; k < NSTG; k++) begin : g_stg
			localparam logic [prd_pkg::SQ_W-1:0] BIT =
				prd_pkg::SQ_W'(1) << (prd_pkg::SQ_W - 2 - 2 * k);
			logic [prd_pkg::SQ_W-1:0] rem_p;
			logic [prd_pkg::SQ_W-1:0] res_p;
			logic [prd_pkg::SQ_W-1:0] trial;
			logic                     vld_p;
			prd_pkg::carry_t          car_p;

			// previous stage or pipeline entry
			if (k == 0) begin : g_first
				assign rem_p = sq_sum;
				assign res_p = '0;
				assign vld_p = ctl.valid;
				assign car_p = car_in;
			end else begin : g_next
				assign rem_p = rem_s[k-1];
				assign res_p = res_s[k-1];
				assign vld_p = vld_s[k-1];
				assign car_p = car_s[k-1];
			end

			assign trial = res_p + BIT;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (ctl.en) begin
					vld_s[k] <= vld_p;
				end
			end

			// one restoring root step
			always_ff @(posedge clk) begin
				if (ctl.en) begin
					car_s[k] <= car_p;
					if (rem_p >= trial) begin
						rem_s[k] <= rem_p - trial;
						res_s[k] <= (res_p >> 1) + BIT;
					end else begin
						rem_s[k] <= rem_p;
						res_s[k] <= res_p >> 1;
					end
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[NSTG-1];
	assign root      = res_s[NSTG-1][prd_pkg::ROOT_W-1:0];
	assign car_out   = car_s[NSTG-1];

endmodule

`default_nettype wire

@@ src/pinhole_ray_direction.sv @@
// pinhole ray direction: top level, view vector, normalisation and divider pipeline
// depends on prd_pkg, prd_if and prd_isqrt
`default_nettype none

// Pinhole camera ray direction. Each pixel item (column, row, jitter in eighths of a
// pixel) gives one direction item: forward*focal + right*dx + up*dy normalised to unit
// length as saturated Q1.15, with degenerate set and the direction zero when the vector
// is zero. The block takes one item per clock unless the output stalls, and holds no
// state between items. From acceptance to the output register, eight stages build,
// scale and square the vector, 31 stages form the square root one bit each, and 18
// stages divide the three components in parallel lanes and round and saturate. The
// whole pipeline advances whenever the output register is empty or being taken, so
// pix.ready follows dir.ready. Register writes on cfg are always taken and should be
// made while no item is in flight.

module pinhole_ray_direction #(
	parameter int MAX_RESOLUTION = 4096
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	prd_pix_if.sink    pix,
	prd_dir_if.source  dir,
	prd_cfg_if.sink    cfg
);

	localparam logic [16:0] MAX_RES = 17'(MAX_RESOLUTION);
	localparam int DIV_STG = prd_pkg::QUO_W;

	// configuration registers
	logic [prd_pkg::VEC_W-1:0]   fwd_q, right_q, up_q;
	logic [prd_pkg::FOCAL_W-1:0] focal_q;
	logic [prd_pkg::RES_W-1:0]   width_q, height_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q    <= prd_pkg::RST_FORWARD;
			right_q  <= prd_pkg::RST_RIGHT;
			up_q     <= prd_pkg::RST_UP;
			focal_q  <= prd_pkg::RST_FOCAL;
			width_q  <= prd_pkg::RST_WIDTH;
			height_q <= prd_pkg::RST_HEIGHT;
		end else if (cfg.valid) begin
			case (prd_pkg::cfg_reg_t'(cfg.index))
				prd_pkg::REG_FORWARD: fwd_q    <= cfg.data;
				prd_pkg::REG_RIGHT:   right_q  <= cfg.data;
				prd_pkg::REG_UP:      up_q     <= cfg.data;
				prd_pkg::REG_FOCAL:   focal_q  <= cfg.data[prd_pkg::FOCAL_W-1:0];
				prd_pkg::REG_WIDTH:   width_q  <= cfg.data[prd_pkg::RES_W-1:0];
				prd_pkg::REG_HEIGHT:  height_q <= cfg.data[prd_pkg::RES_W-1:0];
				default: ;
			endcase
		end
	end

	// global advance: output register empty or being taken
	logic out_valid_q;
	logic en;
	assign en        = !out_valid_q || dir.ready;
	assign pix.ready = en;

	// stage 1: pixel offsets in eighths
	logic [prd_pkg::RES_W-1:0] w_clamp, h_clamp;
	logic signed [prd_pkg::OFS_W-1:0] ox, oy;
	logic signed [prd_pkg::OFS_W-1:0] ox_s1, oy_s1;
	logic v_s1;

	always_comb begin
		w_clamp = ({4'b0, width_q} > MAX_RES) ? MAX_RES[prd_pkg::RES_W-1:0] : width_q;
		h_clamp = ({4'b0, height_q} > MAX_RES) ? MAX_RES[prd_pkg::RES_W-1:0] : height_q;
		ox = $signed({3'b0, pix.pixel_x, 3'b0}) + 18'sd4
			+ $signed({{14{pix.jitter_x[3]}}, pix.jitter_x})
			- $signed({3'b0, w_clamp, 2'b0});
		oy = $signed({3'b0, pix.pixel_y, 3'b0}) + 18'sd4
			+ $signed({{14{pix.jitter_y[3]}}, pix.jitter_y})
			- $signed({3'b0, h_clamp, 2'b0});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ox_s1 <= ox;
			oy_s1 <= oy;
		end
	end

	// stage 2: nine products
	logic signed [prd_pkg::OFS_W-1:0] f8;
	logic signed [prd_pkg::PROD_W-1:0] pf_s2[3], pr_s2[3], pu_s2[3];
	logic v_s2;

	assign f8 = $signed({1'b0, focal_q, 1'b0});

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				pf_s2[c] <= $signed(fwd_q[16*c +: 16]) * f8;
				pr_s2[c] <= $signed(right_q[16*c +: 16]) * ox_s1;
				pu_s2[c] <= $signed(up_q[16*c +: 16]) * oy_s1;
			end
		end
	end

	// stage 3: component sums
	logic signed [prd_pkg::SUM_W-1:0] vec_s3[3];
	logic v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				vec_s3[c] <= prd_pkg::SUM_W'(pf_s2[c]) + prd_pkg::SUM_W'(pr_s2[c])
					+ prd_pkg::SUM_W'(pu_s2[c]);
			end
		end
	end

	// stage 4: sign and magnitude
	logic [prd_pkg::MAG_W-1:0] mag_s4[3];
	logic [2:0] neg_s4;
	logic v_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				neg_s4[c] <= vec_s3[c][prd_pkg::SUM_W-1];
				mag_s4[c] <= prd_pkg::MAG_W'(vec_s3[c][prd_pkg::SUM_W-1] ? -vec_s3[c]
					: vec_s3[c]);
			end
		end
	end

	// stage 5: leading one of the largest magnitude
	logic [prd_pkg::MAG_W-1:0] mag_or;
	logic [prd_pkg::POS_W-1:0] lead;
	logic [prd_pkg::MAG_W-1:0] mag_s5[3];
	logic [prd_pkg::POS_W-1:0] lead_s5;
	logic [2:0] neg_s5;
	logic deg_s5, v_s5;

	always_comb begin
		mag_or = mag_s4[0] | mag_s4[1] | mag_s4[2];
		lead   = '0;
		for (int i = 0; i < prd_pkg::MAG_W; i++) begin
			if (mag_or[i]) begin
				lead = prd_pkg::POS_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5  <= mag_s4;
			lead_s5 <= lead;
			neg_s5  <= neg_s4;
			deg_s5  <= (mag_or == '0);
		end
	end

	// stage 6: shift so the top one sits in bit 29
	localparam logic [prd_pkg::POS_W-1:0] TOP_POS = prd_pkg::POS_W'(prd_pkg::NRM_W - 1);
	prd_pkg::carry_t car_s6;
	logic v_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				if (lead_s5 > TOP_POS) begin
					car_s6.mag[c] <= prd_pkg::NRM_W'(mag_s5[c] >> (lead_s5 - TOP_POS));
				end else begin
					car_s6.mag[c] <= prd_pkg::NRM_W'(mag_s5[c] << (TOP_POS - lead_s5));
				end
			end
			car_s6.neg <= neg_s5;
			car_s6.deg <= deg_s5;
		end
	end

	// stage 7: squares
	logic [2*prd_pkg::NRM_W-1:0] sq_s7[3];
	prd_pkg::carry_t car_s7;
	logic v_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				sq_s7[c] <= car_s6.mag[c] * car_s6.mag[c];
			end
			car_s7 <= car_s6;
		end
	end

	// stage 8: sum of squares
	logic [prd_pkg::SQ_W-1:0] ss_s8;
	prd_pkg::carry_t car_s8;
	logic v_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s8  <= prd_pkg::SQ_W'(sq_s7[0]) + prd_pkg::SQ_W'(sq_s7[1])
				+ prd_pkg::SQ_W'(sq_s7[2]);
			car_s8 <= car_s7;
		end
	end

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// square root pipeline
	prd_pkg::pipe_ctl_t    sqrt_ctl;
	logic                  sqrt_valid;
	logic [prd_pkg::ROOT_W-1:0] sqrt_root;
	prd_pkg::carry_t       sqrt_car;

	assign sqrt_ctl.en    = en;
	assign sqrt_ctl.valid = v_s8;

	prd_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (sqrt_ctl),
		.sq_sum    (ss_s8),
		.car_in    (car_s8),
		.out_valid (sqrt_valid),
		.root      (sqrt_root),
		.car_out   (sqrt_car)
	);

	// divider entry: dividend m*32768 + r/2 split into remainder and low bits
	logic [prd_pkg::NUM_W-1:0] num[3];
	logic [prd_pkg::REM_W-1:0] dn_rem_s9[3];
	logic [prd_pkg::QUO_W-1:0] dn_lo_s9[3];
	logic [prd_pkg::ROOT_W-1:0] dn_r_s9;
	logic [2:0] dn_neg_s9;
	logic dn_deg_s9, dn_v_s9;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			num[c] = prd_pkg::NUM_W'({sqrt_car.mag[c], 15'b0})
				+ prd_pkg::NUM_W'(sqrt_root[prd_pkg::ROOT_W-1:1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				dn_rem_s9[c] <= prd_pkg::REM_W'(num[c][prd_pkg::NUM_W-1:prd_pkg::QUO_W]);
				dn_lo_s9[c]  <= num[c][prd_pkg::QUO_W-1:0];
			end
			dn_r_s9   <= sqrt_root;
			dn_neg_s9 <= sqrt_car.neg;
			dn_deg_s9 <= sqrt_car.deg;
		end
	end

	// divider steps: one quotient bit per stage in three lanes
	logic [prd_pkg::REM_W-1:0]  dv_rem_s10[DIV_STG][3];
	logic [prd_pkg::QUO_W-1:0]  dv_lo_s10[DIV_STG][3];
	logic [prd_pkg::QUO_W-1:0]  dv_q_s10[DIV_STG][3];
	logic [prd_pkg::ROOT_W-1:0] dv_r_s10[DIV_STG];
	logic [2:0]                 dv_neg_s10[DIV_STG];
	logic                       dv_deg_s10[DIV_STG];
	logic                       dv_v_s10[DIV_STG];

	genvar j;
	generate
		for (j = 0; j < DIV_STG; j++) begin : g_div
			logic [prd_pkg::REM_W-1:0]  rem_p[3];
			logic [prd_pkg::QUO_W-1:0]  lo_p[3];
			logic [prd_pkg::QUO_W-1:0]  q_p[3];
			logic [prd_pkg::ROOT_W-1:0] r_p;
			logic [2:0]                 neg_p;
			logic                       deg_p, v_p;

			if (j == 0) begin : g_first
				assign rem_p = dn_rem_s9;
				assign lo_p  = dn_lo_s9;
				assign q_p   = '{default: '0};
				assign r_p   = dn_r_s9;
				assign neg_p = dn_neg_s9;
				assign deg_p = dn_deg_s9;
				assign v_p   = dn_v_s9;
			end else begin : g_next
				assign rem_p = dv_rem_s10[j-1];
				assign lo_p  = dv_lo_s10[j-1];
				assign q_p   = dv_q_s10[j-1];
				assign r_p   = dv_r_s10[j-1];
				assign neg_p = dv_neg_s10[j-1];
				assign deg_p = dv_deg_s10[j-1];
				assign v_p   = dv_v_s10[j-1];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v_s10[j] <= 1'b0;
				end else if (en) begin
					dv_v_s10[j] <= v_p;
				end
			end

			always_ff @(posedge clk) begin
				logic [prd_pkg::REM_W-1:0] t;
				logic ge;
				if (en) begin
					for (int c = 0; c < 3; c++) begin
						t  = {rem_p[c][prd_pkg::REM_W-2:0], lo_p[c][prd_pkg::QUO_W-1]};
						ge = (t >= {1'b0, r_p});
						dv_rem_s10[j][c] <= ge ? t - {1'b0, r_p} : t;
						dv_lo_s10[j][c]  <= lo_p[c] << 1;
						dv_q_s10[j][c]   <= {q_p[c][prd_pkg::QUO_W-2:0], ge};
					end
					dv_r_s10[j]   <= r_p;
					dv_neg_s10[j] <= neg_p;
					dv_deg_s10[j] <= deg_p;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_v_s9 <= 1'b0;
		end else if (en) begin
			dn_v_s9 <= sqrt_valid;
		end
	end

	// output register: saturate, apply sign, zero a degenerate item
	logic [prd_pkg::DIR_W-1:0] dir_q[3];
	logic deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_v_s10[DIV_STG-1];
		end
	end

	always_ff @(posedge clk) begin
		logic [prd_pkg::DIR_W-1:0] sat;
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				sat = (dv_q_s10[DIV_STG-1][c] > prd_pkg::DIR_MAX) ? prd_pkg::DIR_MAX
					: dv_q_s10[DIV_STG-1][c];
				if (dv_deg_s10[DIV_STG-1]) begin
					dir_q[c] <= '0;
				end else if (dv_neg_s10[DIV_STG-1][c]) begin
					dir_q[c] <= ~sat + 16'd1;
				end else begin
					dir_q[c] <= sat;
				end
			end
			deg_q <= dv_deg_s10[DIV_STG-1];
		end
	end

	assign dir.valid      = out_valid_q;
	assign dir.dir_x      = $signed(dir_q[0]);
	assign dir.dir_y      = $signed(dir_q[1]);
	assign dir.dir_z      = $signed(dir_q[2]);
	assign dir.degenerate = deg_q;

`ifndef SYNTH
	// a degenerate item carries a zero direction
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dir.valid && dir.degenerate |-> dir.dir_x == 16'sd0 && dir.dir_y == 16'sd0
			&& dir.dir_z == 16'sd0)
		else $error("degenerate item with non-zero direction");

	// a normalised direction has at least one component of magnitude one half or more
	a_unit_len: assert property (@(posedge clk) disable iff (!arst_n)
		dir.valid && !dir.degenerate |->
			dir.dir_x >= 16'sd16384 || dir.dir_x <= -16'sd16384
			|| dir.dir_y >= 16'sd16384 || dir.dir_y <= -16'sd16384
			|| dir.dir_z >= 16'sd16384 || dir.dir_z <= -16'sd16384)
		else $error("direction far from unit length");

	// a stalled result stays in the output register
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dir.valid && !dir.ready |=> dir.valid && $stable(dir_q[0]) && $stable(deg_q))
		else $error("stalled item lost");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_prd_if.sv @@
// testbench note: the channel interfaces live in src/prd_if.sv and are reused as is
// this file holds no extra interface; it depends on no other file
`timescale 1ns / 100ps
`default_nettype none

package tb_prd_types;
	// one pixel item as the stimulus side sees it
	typedef struct {
		logic [11:0] px;
		logic [11:0] py;
		logic [3:0]  jx;
		logic [3:0]  jy;
	} pix_item_t;

	// one expected direction item
	typedef struct {
		logic [15:0] dx;
		logic [15:0] dy;
		logic [15:0] dz;
		logic        deg;
	} dir_item_t;
endpackage

`default_nettype wire

@@ tb/sv/tb_pinhole_ray_direction.sv @@
// testbench for pinhole_ray_direction: directed and random pixel items against a
// built-in predictor of the normalised ray direction; depends on prd_pkg, prd_if, tb_prd_types
`timescale 1ns / 100ps
`default_nettype none

module tb_pinhole_ray_direction;

	localparam int LATENCY = 57;
	localparam int MAX_RES = 4096;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	prd_pix_if pix ();
	prd_dir_if dir ();
	prd_cfg_if cfg ();

	pinhole_ray_direction #(.MAX_RESOLUTION(MAX_RES)) dut (
		.clk(clk), .arst_n(arst_n), .pix(pix), .dir(dir), .cfg(cfg)
	);

	always #5 clk = ~clk;

	// predictor copy of the camera registers
	logic [47:0] cam_fwd, cam_right, cam_up;
	logic [15:0] cam_focal;
	logic [12:0] cam_w, cam_h;

	tb_prd_types::dir_item_t expected_dirs[$];
	int errors = 0;
	int items_seen = 0;
	bit stall_long = 0;
	int stall_cycles = 0;

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("mismatch %s: got %h want %h (item %0d)", what, got, want, items_seen);
		errors++;
	endtask

	function automatic logic [63:0] root_of(input logic [63:0] s);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint basis(input logic [47:0] v, input int k);
		logic signed [15:0] c;
		c = v[16*k +: 16];
		return longint'(c);
	endfunction

	// unit ray direction for one pixel item
	function automatic tb_prd_types::dir_item_t ray_direction(input tb_prd_types::pix_item_t it);
		tb_prd_types::dir_item_t r;
		longint w, h, f8, ox, oy, v;
		logic [63:0] mag[3];
		logic [63:0] mx, s, rt, q;
		bit neg[3];
		logic signed [3:0] jx, jy;
		jx = it.jx;
		jy = it.jy;
		w = (cam_w > MAX_RES) ? MAX_RES : cam_w;
		h = (cam_h > MAX_RES) ? MAX_RES : cam_h;
		f8 = longint'(cam_focal) * 2;
		ox = 8 * longint'(it.px) + 4 + longint'(jx) - 4 * w;
		oy = 8 * longint'(it.py) + 4 + longint'(jy) - 4 * h;
		mx = 0;
		for (int k = 0; k < 3; k++) begin
			v = basis(cam_fwd, k) * f8 + basis(cam_right, k) * ox + basis(cam_up, k) * oy;
			neg[k] = v < 0;
			mag[k] = neg[k] ? -v : v;
			if (mag[k] > mx) mx = mag[k];
		end
		r = '{16'd0, 16'd0, 16'd0, 1'b1};
		if (mx == 0) return r;
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int k = 0; k < 3; k++) mag[k] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int k = 0; k < 3; k++) mag[k] <<= 1;
		end
		s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		rt = root_of(s);
		for (int k = 0; k < 3; k++) begin
			q = (mag[k] * 32768 + rt / 2) / rt;
			if (q > 32767) q = 32767;
			q = neg[k] ? -q : q;
			if (k == 0) r.dx = q[15:0];
			else if (k == 1) r.dy = q[15:0];
			else r.dz = q[15:0];
		end
		r.deg = 1'b0;
		return r;
	endfunction

	// drive one pixel item with a random lead-in gap
	task automatic send_pixel(input tb_prd_types::pix_item_t it, input bit gaps = 1);
		int gap;
		gap = gaps ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			pix.valid <= 1'b0;
			@(negedge clk);
		end
		pix.valid <= 1'b1;
		pix.pixel_x <= it.px;
		pix.pixel_y <= it.py;
		pix.jitter_x <= it.jx;
		pix.jitter_y <= it.jy;
		do @(posedge clk); while (!pix.ready);
		expected_dirs.push_back(ray_direction(it));
		@(negedge clk);
	endtask

	task automatic idle_pix;
		pix.valid <= 1'b0;
	endtask

	// wait until the pipeline has drained
	task automatic drain;
		idle_pix();
		while (expected_dirs.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reg(input prd_pkg::cfg_reg_t idx, input logic [47:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			prd_pkg::REG_FORWARD: cam_fwd = val;
			prd_pkg::REG_RIGHT:   cam_right = val;
			prd_pkg::REG_UP:      cam_up = val;
			prd_pkg::REG_FOCAL:   cam_focal = val[15:0];
			prd_pkg::REG_WIDTH:   cam_w = val[12:0];
			prd_pkg::REG_HEIGHT:  cam_h = val[12:0];
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	// unknown index: nothing in the predictor changes
	task automatic write_bad_index(input logic [2:0] idx, input logic [47:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic tb_prd_types::pix_item_t rand_pixel();
		tb_prd_types::pix_item_t it;
		it.px = $urandom;
		it.py = $urandom;
		it.jx = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8) - 4);
		it.jy = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8) - 4);
		return it;
	endfunction

	function automatic logic [47:0] rand_basis();
		logic [47:0] v;
		v = {$urandom, $urandom};
		// mostly full-range components, sometimes modest or zero
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(0, 3))
				0: v[16*k +: 16] = 16'(int'($urandom_range(0, 32768)) - 16384);
				1: v[16*k +: 16] = 16'd0;
				default: ;
			endcase
		end
		return v;
	endfunction

	// receiver: a random wait before each item, and the long hold-off
	initial begin
		int wait_n;
		dir.ready = 1'b0;
		@(negedge clk);
		forever begin
			wait_n = $urandom_range(0, 3);
			while (stall_long && stall_cycles > 0) begin
				dir.ready <= 1'b0;
				stall_cycles--;
				@(negedge clk);
			end
			repeat (wait_n) begin
				dir.ready <= 1'b0;
				@(negedge clk);
			end
			dir.ready <= 1'b1;
			do @(posedge clk); while (!(arst_n && dir.valid));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		tb_prd_types::dir_item_t e;
		if (arst_n && dir.valid && dir.ready) begin
			items_seen++;
			if (expected_dirs.size() == 0) begin
				$display("unexpected direction item %0d", items_seen);
				errors++;
			end else begin
				e = expected_dirs.pop_front();
				if (dir.dir_x !== e.dx) report("dir_x", dir.dir_x, e.dx);
				if (dir.dir_y !== e.dy) report("dir_y", dir.dir_y, e.dy);
				if (dir.dir_z !== e.dz) report("dir_z", dir.dir_z, e.dz);
				if (dir.degenerate !== e.deg) report("degenerate", dir.degenerate, e.deg);
			end
		end
	end

	task automatic test_directed;
		tb_prd_types::pix_item_t it;
		// corners, centre and jitter extremes at reset settings
		it = '{12'd0, 12'd0, 4'd0, 4'd0};                 send_pixel(it);
		it = '{12'hfff, 12'hfff, 4'd7, 4'd7};             send_pixel(it);
		it = '{12'd0, 12'hfff, 4'h8, 4'h8};               send_pixel(it);
		it = '{12'd320, 12'd240, 4'hc, 4'd4};             send_pixel(it);
		it = '{12'd319, 12'd239, 4'd4, 4'hc};             send_pixel(it);
		it = '{12'd639, 12'd479, 4'h5, 4'h3};             send_pixel(it);
		drain();
		// zero vector: centre pixel with focal zero
		write_reg(prd_pkg::REG_FOCAL, 48'd0);
		write_reg(prd_pkg::REG_WIDTH, 48'd2);
		write_reg(prd_pkg::REG_HEIGHT, 48'd2);
		it = '{12'd1, 12'd1, 4'hc, 4'hc};                 send_pixel(it);
		it = '{12'd0, 12'd0, 4'd4, 4'd4};                 send_pixel(it);
		it = '{12'd0, 12'd1, 4'd4, 4'hc};                 send_pixel(it);
		drain();
		// resolution over the limit, zero resolution, unit component saturation
		write_reg(prd_pkg::REG_WIDTH, 48'h1fff);
		write_reg(prd_pkg::REG_HEIGHT, 48'd0);
		write_reg(prd_pkg::REG_FOCAL, 48'hffff);
		it = '{12'd2048, 12'd0, 4'd0, 4'd0};              send_pixel(it);
		it = '{12'hfff, 12'hfff, 4'd7, 4'h8};             send_pixel(it);
		drain();
		write_reg(prd_pkg::REG_FORWARD, 48'h8000_8000_8000);
		write_reg(prd_pkg::REG_RIGHT, 48'h7fff_7fff_7fff);
		write_reg(prd_pkg::REG_UP, 48'hffff_ffff_ffff);
		write_bad_index(3'd6, 48'h1234);
		write_bad_index(3'd7, 48'h5678);
		it = '{12'd0, 12'hfff, 4'h8, 4'd7};               send_pixel(it);
		it = '{12'hfff, 12'd0, 4'd7, 4'h8};               send_pixel(it);
		drain();
	endtask

	task automatic test_random_settings(input int phases, input int per_phase);
		for (int p = 0; p < phases; p++) begin
			write_reg(prd_pkg::REG_FORWARD, rand_basis());
			write_reg(prd_pkg::REG_RIGHT, rand_basis());
			write_reg(prd_pkg::REG_UP, rand_basis());
			write_reg(prd_pkg::REG_FOCAL, ($urandom_range(0, 3) == 0)
				? 48'($urandom_range(0, 1) * 16'hffff) : 48'($urandom_range(0, 65535)));
			write_reg(prd_pkg::REG_WIDTH, 48'($urandom_range(0, 8191)));
			write_reg(prd_pkg::REG_HEIGHT, 48'($urandom_range(0, 8191)));
			for (int i = 0; i < per_phase; i++) send_pixel(rand_pixel(), p % 3 != 0);
			drain();
		end
	endtask

	task automatic test_backpressure;
		// hold the receiver off while items keep coming so the pipeline fills
		write_reg(prd_pkg::REG_FORWARD, prd_pkg::RST_FORWARD);
		write_reg(prd_pkg::REG_RIGHT, prd_pkg::RST_RIGHT);
		write_reg(prd_pkg::REG_UP, prd_pkg::RST_UP);
		write_reg(prd_pkg::REG_FOCAL, 48'(prd_pkg::RST_FOCAL));
		write_reg(prd_pkg::REG_WIDTH, 48'(prd_pkg::RST_WIDTH));
		write_reg(prd_pkg::REG_HEIGHT, 48'(prd_pkg::RST_HEIGHT));
		stall_cycles = 200;
		stall_long = 1;
		for (int i = 0; i < 120; i++) send_pixel(rand_pixel(), 0);
		stall_long = 0;
		drain();
		// sender pause until all results are back, then carry on
		for (int i = 0; i < 40; i++) send_pixel(rand_pixel());
		drain();
	endtask

	initial begin
		pix.valid = 1'b0;
		pix.pixel_x = '0;
		pix.pixel_y = '0;
		pix.jitter_x = '0;
		pix.jitter_y = '0;
		cfg.valid = 1'b0;
		cfg.index = prd_pkg::REG_FORWARD;
		cfg.data = '0;
		cam_fwd = prd_pkg::RST_FORWARD;
		cam_right = prd_pkg::RST_RIGHT;
		cam_up = prd_pkg::RST_UP;
		cam_focal = prd_pkg::RST_FOCAL;
		cam_w = prd_pkg::RST_WIDTH;
		cam_h = prd_pkg::RST_HEIGHT;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_random_settings(12, 60);
		drain();
		if (errors == 0 && expected_dirs.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// overall time limit
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
src/prd_pkg.sv
src/prd_if.sv
src/prd_isqrt.sv
src/pinhole_ray_direction.sv
tb/sv/tb_prd_if.sv
tb/sv/tb_pinhole_ray_direction.sv
